// ===== rtl/core/time_amplitude_record_gate_unit_assert.svh =====
// assertion macros for the record gate
`ifndef TIME_AMPLITUDE_RECORD_GATE_UNIT_ASSERT_SVH
`define TIME_AMPLITUDE_RECORD_GATE_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TARG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("record gate check failed");

// next-cycle implication, checked outside reset
`define TARG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("record gate check failed");

`endif

// ===== rtl/core/targ_pkg.sv =====
// shared constants, codes and types of the record gate
`timescale 1ns / 1ps

package targ_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int COUNT_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int MODE_BITS = 4;
    localparam int REG_COUNT = 8;
    localparam int REG_INDEX_BITS = $clog2(REG_COUNT);
    localparam int IDX_BITS = ((COUNT_BITS > SAMPLE_BITS) ? COUNT_BITS : SAMPLE_BITS) + 2;
    localparam int PROD_BITS = IDX_BITS + SAMPLE_BITS;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic signed [IDX_BITS-1:0] wide_t;
    typedef logic [MODE_BITS-1:0] mode_t;
    typedef logic [REG_INDEX_BITS-1:0] reg_index_t;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    localparam mode_t MODE_TIME_OUT = mode_t'(0);
    localparam mode_t MODE_TIME_IN = mode_t'(1);
    localparam mode_t MODE_AMP_OUT = mode_t'(2);
    localparam mode_t MODE_AMP_IN = mode_t'(3);
    localparam mode_t MODE_BOTH_OUT = mode_t'(4);
    localparam mode_t MODE_BOTH_IN = mode_t'(5);
    localparam mode_t MODE_SORTED_DUP = mode_t'(7);
    localparam mode_t MODE_INDEX_WIN = mode_t'(8);

    localparam reg_index_t REG_MODE = reg_index_t'(0);
    localparam reg_index_t REG_SERIES_KIND = reg_index_t'(1);
    localparam reg_index_t REG_TIME_LOW = reg_index_t'(2);
    localparam reg_index_t REG_TIME_HIGH = reg_index_t'(3);
    localparam reg_index_t REG_AMP_LOW = reg_index_t'(4);
    localparam reg_index_t REG_AMP_HIGH = reg_index_t'(5);
    localparam reg_index_t REG_STEP_SLOPE = reg_index_t'(6);
    localparam reg_index_t REG_START_INTERCEPT = reg_index_t'(7);

    localparam sample_t STEP_SLOPE_RESET = sample_t'(65536);

    typedef struct packed {
        mode_t mode;
        logic series_kind;
        sample_t time_low;
        sample_t time_high;
        sample_t amp_low;
        sample_t amp_high;
        sample_t step_slope;
        sample_t start_intercept;
    } cfg_t;

    typedef struct packed {
        sample_t sample_time;
        sample_t sample_value;
        logic bad_in;
    } in_beat_t;

    typedef struct packed {
        count_t record_index;
        count_t written_count;
        sample_t previous_time;
        logic previous_valid;
    } gate_state_t;

    typedef struct packed {
        logic keep;
        logic bad;
        logic err;
        logic flag;
        logic start_load;
        logic prev_load;
        wide_t mul_k;
    } decide_t;

endpackage

// ===== rtl/core/targ_in_if.sv =====
// input record channel
`timescale 1ns / 1ps

interface targ_in_if;
    logic valid;
    logic ready;
    targ_pkg::sample_t sample_time;
    targ_pkg::sample_t sample_value;
    logic bad_in;

    modport source (output valid, output sample_time, output sample_value, output bad_in,
                    input ready);
    modport sink (input valid, input sample_time, input sample_value, input bad_in,
                  output ready);
endinterface

// ===== rtl/core/targ_out_if.sv =====
// result channel
`timescale 1ns / 1ps

interface targ_out_if;
    logic valid;
    logic ready;
    logic keep;
    logic bad_out;
    logic order_error;
    targ_pkg::sample_t series_start;
    targ_pkg::count_t written_total;
    targ_pkg::count_t deleted_total;
    targ_pkg::count_t flagged_total;

    modport source (output valid, output keep, output bad_out, output order_error,
                    output series_start, output written_total, output deleted_total,
                    output flagged_total, input ready);
    modport sink (input valid, input keep, input bad_out, input order_error,
                  input series_start, input written_total, input deleted_total,
                  input flagged_total, output ready);
endinterface

// ===== rtl/core/time_amplitude_record_gate_unit.sv =====
// top level of the time and amplitude record gate
//
// channel   | dir | handshake     | payload
// ----------+-----+---------------+------------------------------------------------
// samples   | in  | valid / ready | sample_time, sample_value, bad_in
// results   | out | valid / ready | keep, bad_out, order_error, series_start, totals
// wr_*      | in  | wr_en only    | wr_index, wr_data
//
// one record per cycle sustained while results.ready stays high
// records land in an input register, decision and counters settle when it advances
// the multiply-add for the series start sits in that same step
// a held result stalls the input register, which then stalls samples.ready
// reset clears counters, history and registers to their defaults at once
`timescale 1ns / 1ps

`include "time_amplitude_record_gate_unit_assert.svh"

module time_amplitude_record_gate_unit
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  targ_pkg::reg_index_t       wr_index,
    input  targ_pkg::sample_t          wr_data,
    targ_in_if.sink                    samples,
    targ_out_if.source                 results
);

    targ_pkg::cfg_t cfg_reg;
    targ_pkg::cfg_t cfg_next;
    logic in_valid_reg;
    logic in_valid_next;
    targ_pkg::in_beat_t in_beat_reg;
    targ_pkg::in_beat_t in_beat_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic keep_reg;
    logic keep_next;
    logic bad_reg;
    logic bad_next;
    logic err_reg;
    logic err_next;
    targ_pkg::count_t index_reg;
    targ_pkg::count_t index_next;
    targ_pkg::count_t written_reg;
    targ_pkg::count_t written_next;
    targ_pkg::count_t deleted_reg;
    targ_pkg::count_t deleted_next;
    targ_pkg::count_t flagged_reg;
    targ_pkg::count_t flagged_next;
    targ_pkg::sample_t start_time_reg;
    targ_pkg::sample_t start_time_next;
    targ_pkg::sample_t prev_time_reg;
    targ_pkg::sample_t prev_time_next;
    logic prev_valid_reg;
    logic prev_valid_next;

    logic take_in;
    logic advance;
    targ_pkg::gate_state_t st;
    targ_pkg::decide_t dec;
    targ_pkg::sample_t series_time;

    assign advance = in_valid_reg && (!out_valid_reg || results.ready);
    assign samples.ready = !in_valid_reg || advance;
    assign take_in = samples.valid && samples.ready;

    assign st.record_index = index_reg;
    assign st.written_count = written_reg;
    assign st.previous_time = prev_time_reg;
    assign st.previous_valid = prev_valid_reg;

    targ_decide u_decide
    (
        .cfg  (cfg_reg),
        .beat (in_beat_reg),
        .st   (st),
        .dec  (dec)
    );

    targ_series u_series
    (
        .mul_k           (dec.mul_k),
        .step_slope      (cfg_reg.step_slope),
        .start_intercept (cfg_reg.start_intercept),
        .series_time     (series_time)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                targ_pkg::REG_MODE:            cfg_next.mode = wr_data[targ_pkg::MODE_BITS-1:0];
                targ_pkg::REG_SERIES_KIND:     cfg_next.series_kind = wr_data[0];
                targ_pkg::REG_TIME_LOW:        cfg_next.time_low = wr_data;
                targ_pkg::REG_TIME_HIGH:       cfg_next.time_high = wr_data;
                targ_pkg::REG_AMP_LOW:         cfg_next.amp_low = wr_data;
                targ_pkg::REG_AMP_HIGH:        cfg_next.amp_high = wr_data;
                targ_pkg::REG_STEP_SLOPE:      cfg_next.step_slope = wr_data;
                targ_pkg::REG_START_INTERCEPT: cfg_next.start_intercept = wr_data;
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_beat_next = in_beat_reg;
        out_valid_next = out_valid_reg;
        keep_next = keep_reg;
        bad_next = bad_reg;
        err_next = err_reg;
        index_next = index_reg;
        written_next = written_reg;
        deleted_next = deleted_reg;
        flagged_next = flagged_reg;
        start_time_next = start_time_reg;
        prev_time_next = prev_time_reg;
        prev_valid_next = prev_valid_reg;

        if (results.valid && results.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            in_valid_next = 1'b0;
            out_valid_next = 1'b1;
            keep_next = dec.keep;
            bad_next = dec.bad;
            err_next = dec.err;
            index_next = index_reg + targ_pkg::count_t'(1);
            if (dec.keep)
            begin
                written_next = (written_reg == '1) ? written_reg
                                                   : written_reg + targ_pkg::count_t'(1);
            end
            else
            begin
                deleted_next = (deleted_reg == '1) ? deleted_reg
                                                   : deleted_reg + targ_pkg::count_t'(1);
            end
            if (dec.flag)
            begin
                flagged_next = (flagged_reg == '1) ? flagged_reg
                                                   : flagged_reg + targ_pkg::count_t'(1);
            end
            if (dec.start_load)
            begin
                start_time_next = series_time;
            end
            if (dec.prev_load)
            begin
                prev_time_next = in_beat_reg.sample_time;
                prev_valid_next = 1'b1;
            end
        end
        if (take_in)
        begin
            in_valid_next = 1'b1;
            in_beat_next.sample_time = samples.sample_time;
            in_beat_next.sample_value = samples.sample_value;
            in_beat_next.bad_in = samples.bad_in;
        end
        // intercept write reloads the series start
        if (wr_en && (wr_index == targ_pkg::REG_START_INTERCEPT))
        begin
            start_time_next = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{mode: targ_pkg::MODE_TIME_OUT, series_kind: 1'b0,
                         time_low: '0, time_high: '0, amp_low: '0, amp_high: '0,
                         step_slope: targ_pkg::STEP_SLOPE_RESET, start_intercept: '0};
            in_valid_reg <= 1'b0;
            in_beat_reg <= '0;
            out_valid_reg <= 1'b0;
            keep_reg <= 1'b0;
            bad_reg <= 1'b0;
            err_reg <= 1'b0;
            index_reg <= '0;
            written_reg <= '0;
            deleted_reg <= '0;
            flagged_reg <= '0;
            start_time_reg <= '0;
            prev_time_reg <= '0;
            prev_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            in_valid_reg <= in_valid_next;
            in_beat_reg <= in_beat_next;
            out_valid_reg <= out_valid_next;
            keep_reg <= keep_next;
            bad_reg <= bad_next;
            err_reg <= err_next;
            index_reg <= index_next;
            written_reg <= written_next;
            deleted_reg <= deleted_next;
            flagged_reg <= flagged_next;
            start_time_reg <= start_time_next;
            prev_time_reg <= prev_time_next;
            prev_valid_reg <= prev_valid_next;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.keep = keep_reg;
    assign results.bad_out = bad_reg;
    assign results.order_error = err_reg;
    assign results.series_start = start_time_reg;
    assign results.written_total = written_reg;
    assign results.deleted_total = deleted_reg;
    assign results.flagged_total = flagged_reg;

    `TARG_ASSERT_NEXT(a_advance_shows_beat, advance, results.valid)
    `TARG_ASSERT_NEXT(a_index_steps, advance, index_reg == $past(index_reg) + targ_pkg::count_t'(1))
    `TARG_ASSERT_NEXT(a_written_holds, !advance, $stable(written_reg) && $stable(deleted_reg))
    `TARG_ASSERT_NOW(a_error_drops, results.valid && results.order_error, !results.keep)

endmodule

// ===== rtl/core/targ_decide.sv =====
// per-record keep, drop, flag and order decision
`timescale 1ns / 1ps

module targ_decide
(
    input  targ_pkg::cfg_t        cfg,
    input  targ_pkg::in_beat_t    beat,
    input  targ_pkg::gate_state_t st,
    output targ_pkg::decide_t     dec
);

    targ_pkg::sample_t t;
    logic t_in;
    logic a_in;
    logic hit;
    logic look;
    targ_pkg::wide_t idx_w;
    targ_pkg::wide_t win_start;
    targ_pkg::wide_t win_end;
    logic in_win;

    assign t = beat.sample_time;
    assign t_in = (t >= cfg.time_low) && (t <= cfg.time_high);
    assign a_in = (beat.sample_value >= cfg.amp_low) && (beat.sample_value <= cfg.amp_high);

    assign idx_w = targ_pkg::wide_t'({1'b0, st.record_index});
    assign win_start = targ_pkg::wide_t'(cfg.time_low >>> targ_pkg::FRAC_BITS);
    assign win_end = win_start + targ_pkg::wide_t'(cfg.time_high >>> targ_pkg::FRAC_BITS);
    assign in_win = (idx_w >= win_start) && (idx_w < win_end);

    // sorted window: equal limits take all, reversed limits take both tails
    assign look = (cfg.time_low == cfg.time_high)
               || ((cfg.time_low < cfg.time_high) && t_in)
               || ((cfg.time_low > cfg.time_high)
                   && ((t <= cfg.time_high) || (t >= cfg.time_low)));

    always_comb
    begin
        case (cfg.mode)
            targ_pkg::MODE_TIME_OUT: hit = !t_in;
            targ_pkg::MODE_TIME_IN:  hit = t_in;
            targ_pkg::MODE_AMP_OUT:  hit = !a_in;
            targ_pkg::MODE_AMP_IN:   hit = a_in;
            targ_pkg::MODE_BOTH_OUT: hit = !t_in && !a_in;
            targ_pkg::MODE_BOTH_IN:  hit = t_in && a_in;
            default:                 hit = 1'b0;
        endcase
    end

    always_comb
    begin
        dec.keep = 1'b1;
        dec.bad = beat.bad_in;
        dec.err = 1'b0;
        dec.flag = 1'b0;
        dec.start_load = 1'b0;
        dec.prev_load = 1'b0;
        dec.mul_k = idx_w + targ_pkg::wide_t'(1);
        if (cfg.mode <= targ_pkg::MODE_BOTH_IN)
        begin
            if (cfg.series_kind && (cfg.mode != targ_pkg::MODE_TIME_OUT))
            begin
                if (hit)
                begin
                    dec.bad = 1'b1;
                    dec.flag = 1'b1;
                end
            end
            else
            begin
                dec.keep = !hit;
                // trimming a leading record moves the series start
                if (cfg.series_kind && hit && (t < cfg.time_low))
                begin
                    dec.start_load = 1'b1;
                end
            end
        end
        else if ((cfg.mode == targ_pkg::MODE_SORTED_DUP) && !cfg.series_kind)
        begin
            if (look)
            begin
                if (st.previous_valid && (st.previous_time == t))
                begin
                    dec.keep = 1'b0;
                end
                else if (st.previous_valid && (st.previous_time > t))
                begin
                    dec.keep = 1'b0;
                    dec.err = 1'b1;
                end
                else
                begin
                    dec.prev_load = 1'b1;
                end
            end
        end
        else if (cfg.mode == targ_pkg::MODE_INDEX_WIN)
        begin
            dec.keep = in_win;
            if (cfg.series_kind && in_win && (st.written_count == '0))
            begin
                dec.start_load = 1'b1;
                dec.mul_k = win_start;
            end
        end
    end

endmodule

// ===== rtl/core/targ_series.sv =====
// saturating series start time: k * step + intercept
`timescale 1ns / 1ps

module targ_series
(
    input  targ_pkg::wide_t   mul_k,
    input  targ_pkg::sample_t step_slope,
    input  targ_pkg::sample_t start_intercept,
    output targ_pkg::sample_t series_time
);

    logic signed [targ_pkg::PROD_BITS-1:0] prod;
    logic [targ_pkg::PROD_BITS-targ_pkg::SAMPLE_BITS:0] prod_top;
    targ_pkg::sample_t prod_sat;
    logic signed [targ_pkg::SAMPLE_BITS:0] sum;

    assign prod = mul_k * step_slope;
    assign prod_top = prod[targ_pkg::PROD_BITS-1:targ_pkg::SAMPLE_BITS-1];

    always_comb
    begin
        if ((&prod_top) || !(|prod_top))
        begin
            prod_sat = prod[targ_pkg::SAMPLE_BITS-1:0];
        end
        else if (prod[targ_pkg::PROD_BITS-1])
        begin
            prod_sat = targ_pkg::SAMPLE_MIN;
        end
        else
        begin
            prod_sat = targ_pkg::SAMPLE_MAX;
        end
    end

    assign sum = {prod_sat[targ_pkg::SAMPLE_BITS-1], prod_sat}
               + {start_intercept[targ_pkg::SAMPLE_BITS-1], start_intercept};

    always_comb
    begin
        if (sum[targ_pkg::SAMPLE_BITS] == sum[targ_pkg::SAMPLE_BITS-1])
        begin
            series_time = sum[targ_pkg::SAMPLE_BITS-1:0];
        end
        else if (sum[targ_pkg::SAMPLE_BITS])
        begin
            series_time = targ_pkg::SAMPLE_MIN;
        end
        else
        begin
            series_time = targ_pkg::SAMPLE_MAX;
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// testbench for the time and amplitude record gate: directed table, then random gate settings
`timescale 1ns / 1ps

module tb_top;
    import targ_pkg::*;

    localparam int RANDOM_RECORDS = 1750;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam mode_t MODE_ALL_COPIES = mode_t'(6);
    localparam mode_t MODE_SPARE = mode_t'(15);

    typedef struct packed {
        logic keep;
        logic bad_out;
        logic order_error;
        sample_t series_start;
        count_t written_total;
        count_t deleted_total;
        count_t flagged_total;
    } verdict_t;

    typedef struct {
        logic is_cfg;
        reg_index_t idx;
        sample_t data;
        sample_t stamp;
        sample_t level;
        logic flag;
        logic keep;
        logic bad_out;
        logic err;
    } plan_row_t;

    logic clk;
    logic rst_n;
    logic wr_en;
    reg_index_t wr_index;
    sample_t wr_data;

    targ_in_if in_ch ();
    targ_out_if out_ch ();

    time_amplitude_record_gate_unit u_top (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(wr_en),
        .wr_index(wr_index),
        .wr_data(wr_data),
        .samples(in_ch),
        .results(out_ch)
    );

    // gate settings as seen by the predictor
    mode_t gate_mode = MODE_TIME_OUT;
    logic series = 1'b0;
    sample_t time_lo = '0;
    sample_t time_hi = '0;
    sample_t amp_lo = '0;
    sample_t amp_hi = '0;
    sample_t slope = STEP_SLOPE_RESET;
    sample_t intercept = '0;

    // gate history
    count_t rec_idx = '0;
    count_t n_written = '0;
    count_t n_deleted = '0;
    count_t n_flagged = '0;
    sample_t start_reg = '0;
    sample_t prev_time = '0;
    logic prev_valid = 1'b0;

    verdict_t verdicts_due[$];
    plan_row_t script[$];
    sample_t sweep = '0;
    logic calm = 1'b0;
    int mismatches = 0;
    int n_order_err = 0;
    int n_settings = 0;

    mode_t range_modes[6] = '{MODE_TIME_OUT, MODE_TIME_IN, MODE_AMP_OUT, MODE_AMP_IN,
                              MODE_BOTH_OUT, MODE_BOTH_IN};

    function automatic count_t bump(count_t c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic sample_t clamp_sample(logic signed [95:0] x);
        if (x > SAMPLE_MAX)
        begin
            return SAMPLE_MAX;
        end
        if (x < SAMPLE_MIN)
        begin
            return SAMPLE_MIN;
        end
        return sample_t'(x);
    endfunction

    // k * m saturated, then + b saturated
    function automatic sample_t series_time(logic signed [47:0] k, sample_t m, sample_t b);
        logic signed [95:0] acc;
        acc = k * m;
        acc = clamp_sample(acc);
        acc = acc + b;
        return clamp_sample(acc);
    endfunction

    function automatic verdict_t gate_record(sample_t stamp, sample_t level, logic flag_in);
        verdict_t v;
        logic t_in;
        logic a_in;
        logic hit;
        logic look;
        logic in_win;
        longint first_idx;
        longint stop_idx;
        longint idx;
        t_in = stamp >= time_lo && stamp <= time_hi;
        a_in = level >= amp_lo && level <= amp_hi;
        v.keep = 1'b1;
        v.bad_out = flag_in;
        v.order_error = 1'b0;
        if (gate_mode <= MODE_BOTH_IN)
        begin
            case (gate_mode)
                MODE_TIME_OUT: hit = !t_in;
                MODE_TIME_IN: hit = t_in;
                MODE_AMP_OUT: hit = !a_in;
                MODE_AMP_IN: hit = a_in;
                MODE_BOTH_OUT: hit = !t_in && !a_in;
                default: hit = t_in && a_in;
            endcase
            if (series && gate_mode != MODE_TIME_OUT)
            begin
                if (hit)
                begin
                    v.bad_out = 1'b1;
                    n_flagged = bump(n_flagged);
                end
            end
            else
            begin
                v.keep = !hit;
                if (series && hit && stamp < time_lo)
                    start_reg = series_time($signed({16'd0, rec_idx}) + 48'sd1, slope, intercept);
            end
        end
        else if (gate_mode == MODE_SORTED_DUP && !series)
        begin
            look = (time_lo == time_hi) || (time_lo < time_hi && t_in) ||
                   (time_lo > time_hi && (stamp <= time_hi || stamp >= time_lo));
            if (look)
            begin
                if (prev_valid && prev_time == stamp)
                begin
                    v.keep = 1'b0;
                end
                else if (prev_valid && prev_time > stamp)
                begin
                    v.keep = 1'b0;
                    v.order_error = 1'b1;
                    n_order_err++;
                end
                else
                begin
                    prev_time = stamp;
                    prev_valid = 1'b1;
                end
            end
        end
        else if (gate_mode == MODE_INDEX_WIN)
        begin
            first_idx = longint'(time_lo >>> FRAC_BITS);
            stop_idx = first_idx + longint'(time_hi >>> FRAC_BITS);
            idx = longint'({32'd0, rec_idx});
            in_win = (first_idx <= 0 || idx >= first_idx) && (stop_idx > 0 && idx < stop_idx);
            v.keep = in_win;
            if (series && in_win && n_written == '0)
                start_reg = series_time(48'(first_idx), slope, intercept);
        end
        if (v.keep)
        begin
            n_written = bump(n_written);
        end
        else
        begin
            n_deleted = bump(n_deleted);
        end
        rec_idx = rec_idx + 1'b1;
        v.series_start = start_reg;
        v.written_total = n_written;
        v.deleted_total = n_deleted;
        v.flagged_total = n_flagged;
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    function automatic sample_t pick_value();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MIN;
            1: return SAMPLE_MAX;
            2: return '0;
            3, 4, 5: return sample_t'($urandom);
            default: return sample_t'($urandom_range(0, 'h80000)) - sample_t'('h40000);
        endcase
    endfunction

    function automatic sample_t near_edge(sample_t lo, sample_t hi);
        case ($urandom_range(0, 7))
            0: return lo - 1;
            1: return lo;
            2: return hi;
            3: return hi + 1;
            4: return lo + sample_t'($urandom_range(0, 'h10000));
            5: return hi - sample_t'($urandom_range(0, 'h10000));
            default: return pick_value();
        endcase
    endfunction

    function automatic void add_cfg(reg_index_t idx, sample_t data);
        plan_row_t row;
        row = '{1'b1, idx, data, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0};
        script.push_back(row);
    endfunction

    function automatic void add_rec(sample_t stamp, sample_t level, logic flag,
                                    logic keep, logic bad_out, logic err);
        plan_row_t row;
        row = '{1'b0, REG_MODE, '0, stamp, level, flag, keep, bad_out, err};
        script.push_back(row);
    endfunction

    task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $error("%s: expected %h, got %h", fname, want, got);
        end
    endtask

    task automatic write_reg(reg_index_t idx, sample_t data);
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= data;
        case (idx)
            REG_MODE: gate_mode = data[MODE_BITS-1:0];
            REG_SERIES_KIND: series = data[0];
            REG_TIME_LOW: time_lo = data;
            REG_TIME_HIGH: time_hi = data;
            REG_AMP_LOW: amp_lo = data;
            REG_AMP_HIGH: amp_hi = data;
            REG_STEP_SLOPE: slope = data;
            default:
            begin
                intercept = data;
                start_reg = data;
            end
        endcase
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic send_record(sample_t stamp, sample_t level, logic flag, output verdict_t want);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.sample_time <= stamp;
        in_ch.sample_value <= level;
        in_ch.bad_in <= flag;
        do
            @(posedge clk);
        while (!in_ch.ready);
        want = gate_record(stamp, level, flag);
    endtask

    task automatic shuffle_settings();
        mode_t m;
        logic kind;
        sample_t t_lo;
        sample_t t_hi;
        sample_t a_lo;
        sample_t a_hi;
        sample_t base;
        sample_t swap;
        int pick;
        int first_idx;
        int span;
        logic [15:0] frac;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            m = range_modes[$urandom_range(0, 5)];
        else if (pick < 15)
            m = MODE_SORTED_DUP;
        else if (pick < 18)
            m = MODE_INDEX_WIN;
        else if (pick == 18)
            m = MODE_ALL_COPIES;
        else
            m = mode_t'($urandom_range(int'(MODE_INDEX_WIN) + 1, int'(MODE_SPARE)));
        kind = $urandom_range(0, 1);
        t_lo = pick_value();
        t_hi = pick_value();
        if (t_lo > t_hi && $urandom_range(0, 4) != 0)
        begin
            swap = t_lo;
            t_lo = t_hi;
            t_hi = swap;
        end
        a_lo = pick_value();
        a_hi = pick_value();
        if (a_lo > a_hi && $urandom_range(0, 4) != 0)
        begin
            swap = a_lo;
            a_lo = a_hi;
            a_hi = swap;
        end
        if (m == MODE_SORTED_DUP)
        begin
            kind = ($urandom_range(0, 3) == 0);
            base = prev_valid ? prev_time : pick_value();
            if ($urandom_range(0, 4) == 0)
                sweep = base - sample_t'($urandom_range(1, 'h20000));
            else
                sweep = base + sample_t'($urandom_range(0, 'h20000));
            case ($urandom_range(0, 2))
                0:
                begin
                    t_lo = sweep + sample_t'($urandom_range(0, 'h40000));
                    t_hi = t_lo;
                end
                1:
                begin
                    t_lo = sweep - sample_t'($urandom_range(0, 'h10000));
                    t_hi = t_lo + sample_t'($urandom_range('h10000, 'h400000));
                end
                default:
                begin
                    t_hi = sweep + sample_t'($urandom_range(0, 'h100000));
                    t_lo = t_hi + sample_t'($urandom_range(1, 'h400000));
                end
            endcase
        end
        else if (m == MODE_INDEX_WIN)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                first_idx = int'(rec_idx) + $urandom_range(0, 30);
            else if (pick < 8)
                first_idx = -$urandom_range(0, 20);
            else
                first_idx = $urandom_range(0, 200);
            span = ($urandom_range(0, 7) == 0) ? -$urandom_range(0, 5) : $urandom_range(0, 40);
            frac = $urandom_range(0, 'hffff);
            t_lo = {first_idx[15:0], frac};
            frac = $urandom_range(0, 'hffff);
            t_hi = {span[15:0], frac};
            if ($urandom_range(0, 9) == 0)
                t_lo = pick_value();
        end
        write_reg(REG_SERIES_KIND, sample_t'(kind));
        write_reg(REG_TIME_LOW, t_lo);
        write_reg(REG_TIME_HIGH, t_hi);
        write_reg(REG_AMP_LOW, a_lo);
        write_reg(REG_AMP_HIGH, a_hi);
        write_reg(REG_STEP_SLOPE, ($urandom_range(0, 3) == 0) ? STEP_SLOPE_RESET : pick_value());
        write_reg(REG_START_INTERCEPT, pick_value());
        write_reg(REG_MODE, sample_t'(m));
        n_settings++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : sink_pacing
        int stall;
        stall = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall == 0 && $urandom_range(0, 3) == 0)
                stall = pick_gap();
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin : result_check
        verdict_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    mismatches++;
                    $error("result beat with no record pending");
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    check_field("keep", want.keep, out_ch.keep);
                    check_field("bad_out", want.bad_out, out_ch.bad_out);
                    check_field("order_error", want.order_error, out_ch.order_error);
                    check_field("series_start", want.series_start, out_ch.series_start);
                    check_field("written_total", want.written_total, out_ch.written_total);
                    check_field("deleted_total", want.deleted_total, out_ch.deleted_total);
                    check_field("flagged_total", want.flagged_total, out_ch.flagged_total);
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no beat for %0d cycles", quiet);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        verdict_t want;
        plan_row_t row;
        sample_t stamp;
        sample_t level;
        int random_sent;
        int len;
        int r;
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = REG_MODE;
        wr_data = '0;
        in_ch.valid = 1'b0;
        in_ch.sample_time = '0;
        in_ch.sample_value = '0;
        in_ch.bad_in = 1'b0;
        random_sent = 0;

        // index window in a series while nothing is written yet, the k * step product saturates
        add_cfg(REG_SERIES_KIND, sample_t'(1));
        add_cfg(REG_TIME_LOW, sample_t'('h0002_8000));
        add_cfg(REG_TIME_HIGH, sample_t'('h0003_0000));
        add_cfg(REG_STEP_SLOPE, sample_t'('h7fff_0000));
        add_cfg(REG_START_INTERCEPT, sample_t'('hfffb_0000));
        add_cfg(REG_MODE, sample_t'(MODE_INDEX_WIN));
        add_rec(SAMPLE_MIN, SAMPLE_MAX, 1'b1, 1'b0, 1'b1, 1'b0);
        add_rec(SAMPLE_MAX, SAMPLE_MIN, 1'b0, 1'b0, 1'b0, 1'b0);
        add_rec('0, '0, 1'b0, 1'b1, 1'b0, 1'b0);
        add_rec(SAMPLE_MAX, SAMPLE_MAX, 1'b1, 1'b1, 1'b1, 1'b0);
        add_rec(SAMPLE_MIN, SAMPLE_MIN, 1'b0, 1'b1, 1'b0, 1'b0);
        add_rec('0, '0, 1'b0, 1'b0, 1'b0, 1'b0);
        // time-labeled drop outside [-1.0, 1.0]
        add_cfg(REG_SERIES_KIND, sample_t'(0));
        add_cfg(REG_TIME_LOW, sample_t'('hffff_0000));
        add_cfg(REG_TIME_HIGH, sample_t'('h0001_0000));
        add_cfg(REG_MODE, sample_t'(MODE_TIME_OUT));
        add_rec(SAMPLE_MIN, SAMPLE_MAX, 1'b1, 1'b0, 1'b1, 1'b0);
        add_rec(sample_t'('hffff_0000), SAMPLE_MIN, 1'b0, 1'b1, 1'b0, 1'b0);
        add_rec(sample_t'('h0001_0000), '0, 1'b1, 1'b1, 1'b1, 1'b0);
        add_rec(SAMPLE_MAX, '0, 1'b0, 1'b0, 1'b0, 1'b0);
        // series trims records outside the range, a leading one below it moves the start
        add_cfg(REG_SERIES_KIND, sample_t'(1));
        add_cfg(REG_STEP_SLOPE, STEP_SLOPE_RESET);
        add_cfg(REG_START_INTERCEPT, sample_t'('h0010_0000));
        add_rec(sample_t'('hfffe_0000), '0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_rec(sample_t'('h0002_0000), '0, 1'b0, 1'b0, 1'b0, 1'b0);
        // series flagging, one record per range rule other than time-out
        add_cfg(REG_AMP_LOW, sample_t'('hfffe_0000));
        add_cfg(REG_AMP_HIGH, sample_t'('h0002_0000));
        add_cfg(REG_MODE, sample_t'(MODE_TIME_IN));
        add_rec('0, SAMPLE_MAX, 1'b1, 1'b1, 1'b1, 1'b0);
        add_cfg(REG_MODE, sample_t'(MODE_AMP_OUT));
        add_rec(sample_t'('h0005_0000), sample_t'('h0002_0001), 1'b0, 1'b1, 1'b1, 1'b0);
        add_cfg(REG_MODE, sample_t'(MODE_AMP_IN));
        add_rec('0, sample_t'('h0003_0000), 1'b0, 1'b1, 1'b0, 1'b0);
        add_cfg(REG_MODE, sample_t'(MODE_BOTH_OUT));
        add_rec(sample_t'('h0002_0000), sample_t'('hfffd_0000), 1'b0, 1'b1, 1'b1, 1'b0);
        add_cfg(REG_MODE, sample_t'(MODE_BOTH_IN));
        add_rec(sample_t'('h0001_0000), sample_t'('hfffe_0000), 1'b1, 1'b1, 1'b1, 1'b0);
        // sorted duplicates: repeat, then out of order
        add_cfg(REG_SERIES_KIND, sample_t'(0));
        add_cfg(REG_TIME_LOW, sample_t'('h0004_0000));
        add_cfg(REG_TIME_HIGH, sample_t'('h0004_0000));
        add_cfg(REG_MODE, sample_t'(MODE_SORTED_DUP));
        add_rec(sample_t'('h0005_0000), '0, 1'b0, 1'b1, 1'b0, 1'b0);
        add_rec(sample_t'('h0005_0000), '0, 1'b1, 1'b0, 1'b1, 1'b0);
        add_rec(sample_t'('h0003_0000), '0, 1'b0, 1'b0, 1'b0, 1'b1);
        add_rec(sample_t'('h0006_0000), '0, 1'b0, 1'b1, 1'b0, 1'b0);
        // unused modes pass everything
        add_cfg(REG_MODE, sample_t'(MODE_ALL_COPIES));
        add_rec(sample_t'('hfffe_0000), SAMPLE_MIN, 1'b1, 1'b1, 1'b1, 1'b0);
        add_cfg(REG_MODE, sample_t'(MODE_SPARE));
        add_rec(SAMPLE_MIN, SAMPLE_MAX, 1'b0, 1'b1, 1'b0, 1'b0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            row = script[i];
            if (row.is_cfg)
            begin
                write_reg(row.idx, row.data);
            end
            else
            begin
                send_record(row.stamp, row.level, row.flag, want);
                want.keep = row.keep;
                want.bad_out = row.bad_out;
                want.order_error = row.err;
                verdicts_due.push_back(want);
            end
        end

        while (random_sent < RANDOM_RECORDS)
        begin
            calm = 1'b0;
            shuffle_settings();
            len = $urandom_range(15, 90);
            calm = ($urandom_range(0, 4) == 0);
            repeat (len)
            begin
                if (gate_mode <= MODE_BOTH_IN)
                begin
                    stamp = near_edge(time_lo, time_hi);
                    level = near_edge(amp_lo, amp_hi);
                end
                else if (gate_mode == MODE_SORTED_DUP)
                begin
                    // mostly a rising sweep with repeats, some steps back and noise
                    r = $urandom_range(0, 19);
                    if (r < 5)
                    begin
                        stamp = sweep;
                    end
                    else if (r < 16)
                    begin
                        sweep = sweep + sample_t'($urandom_range(1, 'h8000));
                        stamp = sweep;
                    end
                    else if (r < 18)
                    begin
                        stamp = sweep - sample_t'($urandom_range(1, 'h10000));
                    end
                    else
                    begin
                        stamp = pick_value();
                    end
                    level = pick_value();
                end
                else
                begin
                    stamp = pick_value();
                    level = pick_value();
                end
                send_record(stamp, level, $urandom_range(0, 1), want);
                verdicts_due.push_back(want);
                random_sent++;
            end
        end
        calm = 1'b0;

        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d records over %0d random gate settings plus the directed table",
                 rec_idx, n_settings);
        $display("%0d written, %0d dropped, %0d flagged bad, %0d out-of-order, %0d mismatches",
                 n_written, n_deleted, n_flagged, n_order_err, mismatches);
        if (mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
